@@ design/ramr_pkg.sv @@
// shared types and constants for the rational add / multiply / reduce block
// no dependencies; every other file uses this package by scoped names
package ramr_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int SUM_W         = PROD_W + 1;
    localparam int MAG_W         = PROD_W;
    localparam int RES_NUM_W     = 33;
    localparam int RES_DEN_W     = 32;
    localparam int WIDE_W        = 64;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_MUL = 2'd1,
        CMD_CMP = 2'd2
    } t_cmd;

    // one classified request waiting for the back end
    typedef struct packed {
        logic                     reduce;
        logic                     is_equal;
        logic signed [SUM_W-1:0]  num;
        logic signed [PROD_W-1:0] den;
    } t_work;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } t_back_state;

endpackage

@@ design/ramr_front.sv @@
// front end: accepts requests, forms the products and sums, classifies
// depends on ramr_pkg
module ramr_front (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_stall,
    input  logic [1:0]                                    i_command,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0]     i_a_num,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0]     i_a_den,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0]     i_b_num,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0]     i_b_den,
    output logic                                          o_push,
    output ramr_pkg::t_work                               o_work,
    input  logic                                          i_q_full
);

    localparam int W  = ramr_pkg::OPERAND_WIDTH;
    localparam int PW = ramr_pkg::PROD_W;
    localparam int SW = ramr_pkg::SUM_W;

    // stage a: captured operands
    logic                r_a_valid;
    ramr_pkg::t_cmd      r_a_cmd;
    logic signed [W-1:0] r_a_an, r_a_ad, r_a_bn, r_a_bd;

    // stage b: registered products
    logic                 r_b_valid;
    ramr_pkg::t_cmd       r_b_cmd;
    logic                 r_b_eq;
    logic signed [PW-1:0] r_b_p0, r_b_p1, r_b_pd;

    logic                 b_load, a_load, a_move;
    logic signed [W-1:0]  mul_rhs;
    logic signed [PW-1:0] p0, p1, pd;
    logic                 a_eq;
    logic signed [SW-1:0] num;
    logic signed [PW-1:0] den;

    assign o_push  = r_b_valid && !i_q_full;
    assign b_load  = !r_b_valid || o_push;
    assign a_move  = r_a_valid && b_load;
    assign a_load  = !r_a_valid || b_load;
    assign o_stall = !a_load;

    // multiply needs a_num*b_num, add needs b_den*a_num
    assign mul_rhs = (r_a_cmd == ramr_pkg::CMD_MUL) ? r_a_bn : r_a_bd;
    assign p0 = PW'(r_a_ad) * PW'(r_a_bn);
    assign p1 = PW'(r_a_an) * PW'(mul_rhs);
    assign pd = PW'(r_a_ad) * PW'(r_a_bd);
    assign a_eq = (r_a_cmd == ramr_pkg::CMD_CMP) && (r_a_an == r_a_bn) && (r_a_ad == r_a_bd);

    always_comb begin
        case (r_b_cmd)
            ramr_pkg::CMD_ADD: begin
                num = SW'(r_b_p0) + SW'(r_b_p1);
                den = r_b_pd;
            end
            ramr_pkg::CMD_MUL: begin
                num = SW'(r_b_p1);
                den = r_b_pd;
            end
            default: begin
                num = '0;
                den = '0;
            end
        endcase
    end

    always_comb begin
        o_work.num      = num;
        o_work.den      = den;
        o_work.is_equal = r_b_eq;
        o_work.reduce   = (num != '0) && (den != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_load) begin
                r_a_valid <= i_valid;
            end
            if (b_load) begin
                r_b_valid <= a_move;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load && i_valid) begin
            r_a_cmd <= ramr_pkg::t_cmd'(i_command);
            r_a_an  <= i_a_num;
            r_a_ad  <= i_a_den;
            r_a_bn  <= i_b_num;
            r_a_bd  <= i_b_den;
        end
        if (a_move) begin
            r_b_cmd <= r_a_cmd;
            r_b_eq  <= a_eq;
            r_b_p0  <= p0;
            r_b_p1  <= p1;
            r_b_pd  <= pd;
        end
    end

endmodule

@@ design/ramr_queue.sv @@
// short request queue between the front and back ends
// depends on ramr_pkg
module ramr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ramr_pkg::t_work i_work,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output ramr_pkg::t_work o_work
);

    localparam int DEPTH = ramr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = ramr_pkg::QPTR_W;
    localparam int CNT_W = ramr_pkg::QCNT_W;

    ramr_pkg::t_work r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_work     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

@@ design/ramr_back.sv @@
// back end: binary gcd with cofactor tracking, result register
// depends on ramr_pkg
module ramr_back (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_nonempty,
    input  ramr_pkg::t_work                           i_work,
    output logic                                      o_pop,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [ramr_pkg::RES_NUM_W-1:0]     o_res_num,
    output logic signed [ramr_pkg::RES_DEN_W-1:0]     o_res_den,
    output logic                                      o_is_equal
);

    localparam int MW = ramr_pkg::MAG_W;
    localparam int SW = ramr_pkg::SUM_W;
    localparam int PW = ramr_pkg::PROD_W;
    localparam int XW = ramr_pkg::WIDE_W;

    ramr_pkg::t_back_state r_state, n_state;

    // invariant: num_mag = p11*x + p12*y and den_mag = p21*x + p22*y, up to the common power of two
    logic [MW-1:0] r_x, r_y, r_p11, r_p12, r_p21, r_p22;
    logic [MW-1:0] n_x, n_y, n_p11, n_p12, n_p21, n_p22;
    logic          r_num_neg, r_den_neg;
    logic signed [SW-1:0] r_res_num;
    logic signed [PW-1:0] r_res_den;
    logic                 r_res_eq;

    logic          r_out_valid;
    logic signed [ramr_pkg::RES_NUM_W-1:0] r_out_num;
    logic signed [ramr_pkg::RES_DEN_W-1:0] r_out_den;
    logic          r_out_eq;

    logic          out_free, out_load, gcd_done;
    logic [MW-1:0] diff_xy, diff_yx, sum_n, sum_d;
    logic signed [SW-1:0] neg_n;
    logic signed [PW-1:0] neg_d;
    logic [MW-1:0] mag_n, mag_d;
    logic [SW-1:0] fin_n_ext;
    logic signed [SW-1:0] fin_num;
    logic signed [PW-1:0] fin_den;
    logic signed [XW-1:0] num_wide, den_wide;

    assign out_free = !r_out_valid || !i_stall;
    assign gcd_done = (r_x == r_y);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ramr_pkg::BK_IDLE: begin
                if (i_nonempty) begin
                    n_state = i_work.reduce ? ramr_pkg::BK_RUN : ramr_pkg::BK_DONE;
                end
            end
            ramr_pkg::BK_RUN: begin
                if (gcd_done) begin
                    n_state = ramr_pkg::BK_DONE;
                end
            end
            ramr_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = ramr_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ramr_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ramr_pkg::BK_IDLE: o_pop    = i_nonempty;
            ramr_pkg::BK_DONE: out_load = out_free;
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // one gcd step
    assign diff_xy = r_x - r_y;
    assign diff_yx = r_y - r_x;

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_p11 = r_p11;
        n_p12 = r_p12;
        n_p21 = r_p21;
        n_p22 = r_p22;
        if (!r_x[0] && !r_y[0]) begin
            n_x = r_x >> 1;
            n_y = r_y >> 1;
        end else if (!r_x[0]) begin
            n_x   = r_x >> 1;
            n_p11 = r_p11 << 1;
            n_p21 = r_p21 << 1;
        end else if (!r_y[0]) begin
            n_y   = r_y >> 1;
            n_p12 = r_p12 << 1;
            n_p22 = r_p22 << 1;
        end else if (r_x > r_y) begin
            // difference of two odds is even, halve in the same step
            n_x   = diff_xy >> 1;
            n_p11 = r_p11 << 1;
            n_p12 = r_p12 + r_p11;
            n_p21 = r_p21 << 1;
            n_p22 = r_p22 + r_p21;
        end else begin
            n_y   = diff_yx >> 1;
            n_p12 = r_p12 << 1;
            n_p11 = r_p11 + r_p12;
            n_p22 = r_p22 << 1;
            n_p21 = r_p21 + r_p22;
        end
    end

    // magnitudes of the incoming terms
    assign neg_n = -i_work.num;
    assign neg_d = -i_work.den;
    assign mag_n = i_work.num[SW-1] ? neg_n[MW-1:0] : i_work.num[MW-1:0];
    assign mag_d = i_work.den[PW-1] ? neg_d[MW-1:0] : i_work.den[MW-1:0];

    // reduced terms once x equals y
    assign sum_n     = r_p11 + r_p12;
    assign sum_d     = r_p21 + r_p22;
    assign fin_n_ext = {1'b0, sum_n};
    assign fin_num   = r_num_neg ? -signed'(fin_n_ext) : signed'(fin_n_ext);
    assign fin_den   = r_den_neg ? -signed'(sum_d) : signed'(sum_d);

    assign num_wide = XW'(r_res_num);
    assign den_wide = XW'(r_res_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ramr_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x       <= mag_n;
            r_y       <= mag_d;
            r_p11     <= MW'(1);
            r_p12     <= '0;
            r_p21     <= '0;
            r_p22     <= MW'(1);
            r_num_neg <= i_work.num[SW-1];
            r_den_neg <= i_work.den[PW-1];
            r_res_num <= i_work.num;
            r_res_den <= i_work.den;
            r_res_eq  <= i_work.is_equal;
        end else if (r_state == ramr_pkg::BK_RUN) begin
            if (gcd_done) begin
                r_res_num <= fin_num;
                r_res_den <= fin_den;
            end else begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_p11 <= n_p11;
                r_p12 <= n_p12;
                r_p21 <= n_p21;
                r_p22 <= n_p22;
            end
        end
        if (out_load) begin
            r_out_num <= num_wide[ramr_pkg::RES_NUM_W-1:0];
            r_out_den <= den_wide[ramr_pkg::RES_DEN_W-1:0];
            r_out_eq  <= r_res_eq;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_num  = r_out_num;
    assign o_res_den  = r_out_den;
    assign o_is_equal = r_out_eq;

endmodule

@@ design/rational_add_multiply_reduce.sv @@
// top level: rational add / multiply with gcd reduction and field compare
// depends on ramr_pkg, ramr_front, ramr_queue, ramr_back
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------------
//   request  | in        | i_valid / o_stall  | i_command, i_a_num, i_a_den, i_b_num, i_b_den
//   result   | out       | o_valid / i_stall  | o_res_num, o_res_den, o_is_equal
//
// the front end takes a request every cycle while o_stall is low, into a two-stage product pipe,
// then a two-entry queue; the back end runs a binary gcd, one shift or subtract-and-halve per
// cycle on 32-bit magnitudes; a reducing request holds the back end in BK_IDLE, then in BK_RUN
// until x equals y, then in BK_DONE; compare requests and those with a zero term skip BK_RUN
// reset is synchronous and active low; it empties the pipe, the queue and the result register
// a stalled result waits in the output register while new requests keep filling the queue
module rational_add_multiply_reduce (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic [1:0]                                i_command,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [ramr_pkg::OPERAND_WIDTH-1:0] i_b_den,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [ramr_pkg::RES_NUM_W-1:0]     o_res_num,
    output logic signed [ramr_pkg::RES_DEN_W-1:0]     o_res_den,
    output logic                                      o_is_equal
);

    logic            push, q_full, pop, q_nonempty;
    ramr_pkg::t_work push_work, head_work;

    ramr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_push    (push),
        .o_work    (push_work),
        .i_q_full  (q_full)
    );

    ramr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_work     (push_work),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_work     (head_work)
    );

    ramr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_work     (head_work),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_is_equal (o_is_equal)
    );

endmodule

@@ bench/rational_add_multiply_reduce_test.sv @@
// self-checking bench for rational_add_multiply_reduce: directed table, then random requests
// results are checked in order against typed table rows or a predictor of add, multiply, gcd reduce and compare
// depends on ramr_pkg and rational_add_multiply_reduce
module rational_add_multiply_reduce_test;

    localparam int OW          = ramr_pkg::OPERAND_WIDTH;
    localparam int NUM_W       = ramr_pkg::RES_NUM_W;
    localparam int DEN_W       = ramr_pkg::RES_DEN_W;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 150;
    localparam int PHASE_ITEMS = 400;
    localparam int DIR_COUNT   = 22;

    // command code with no operation behind it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [OW-1:0] a_num;
        logic signed [OW-1:0] a_den;
        logic signed [OW-1:0] b_num;
        logic signed [OW-1:0] b_den;
    } t_request;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             eq;
    } t_fraction_result;

    typedef struct packed {
        t_request         req;
        logic             typed;
        t_fraction_result want;
    } t_directed_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [1:0]              i_command = ramr_pkg::CMD_ADD;
    logic signed [OW-1:0]    i_a_num = '0;
    logic signed [OW-1:0]    i_a_den = '0;
    logic signed [OW-1:0]    i_b_num = '0;
    logic signed [OW-1:0]    i_b_den = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [NUM_W-1:0] o_res_num;
    logic signed [DEN_W-1:0] o_res_den;
    logic                    o_is_equal;

    int               send_idle_pct = 30;
    int               recv_stall_pct = 72;
    int               mismatch_count = 0;
    int               cycle_count = 0;
    t_fraction_result pending_results[$];
    t_directed_row    directed_rows [DIR_COUNT];

    rational_add_multiply_reduce uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_is_equal (o_is_equal)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // reduced fraction for add and multiply, field-wise equality for compare
    function automatic t_fraction_result predict_fraction(input t_request req);
        longint           n;
        longint           d;
        longint           rn;
        longint           rd;
        longint unsigned  mn;
        longint unsigned  md;
        longint unsigned  x;
        longint unsigned  y;
        longint unsigned  t;
        t_fraction_result r;
        r = '0;
        if (req.cmd == ramr_pkg::CMD_ADD || req.cmd == ramr_pkg::CMD_MUL) begin
            d = longint'(req.a_den) * longint'(req.b_den);
            if (req.cmd == ramr_pkg::CMD_ADD) begin
                n = longint'(req.a_den) * longint'(req.b_num)
                  + longint'(req.b_den) * longint'(req.a_num);
            end else begin
                n = longint'(req.a_num) * longint'(req.b_num);
            end
            mn = (n < 0) ? longint'(-n) : n;
            md = (d < 0) ? longint'(-d) : d;
            // a zero term leaves both terms as computed
            if (mn != 0 && md != 0) begin
                x = mn;
                y = md;
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                mn = mn / x;
                md = md / x;
            end
            rn = (n < 0) ? -longint'(mn) : longint'(mn);
            rd = (d < 0) ? -longint'(md) : longint'(md);
            r.num = rn[NUM_W-1:0];
            r.den = rd[DEN_W-1:0];
        end else if (req.cmd == ramr_pkg::CMD_CMP) begin
            r.eq = (req.a_num == req.b_num) && (req.a_den == req.b_den);
        end
        return r;
    endfunction

    function automatic logic signed [OW-1:0] pick_operand();
        logic signed [OW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b1, {(OW-1){1'b0}}};
                    1: v = {1'b0, {(OW-1){1'b1}}};
                    2: v = {OW{1'b1}};
                    default: v = OW'(1);
                endcase
            end
            2, 3, 4, 5: v = OW'($urandom_range(0, 48)) - OW'(24);
            6: v = OW'($urandom_range(0, 4000)) - OW'(2000);
            default: v = OW'($urandom());
        endcase
        return v;
    endfunction

    task automatic send_request(input t_request req, input t_fraction_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= req.cmd;
        i_a_num   <= req.a_num;
        i_a_den   <= req.a_den;
        i_b_num   <= req.b_num;
        i_b_den   <= req.b_den;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(want);
    endtask

    always @(posedge i_clk) begin
        t_fraction_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: num %0d den %0d eq %0d", $time,
                         o_res_num, o_res_den, o_is_equal);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (o_res_num !== want.num || o_res_den !== want.den
                        || o_is_equal !== want.eq) begin
                    mismatch_count <= mismatch_count + 1;
                    if (o_res_num !== want.num)
                        $display("%0t: res_num expected %0d, got %0d", $time,
                                 $signed(want.num), o_res_num);
                    if (o_res_den !== want.den)
                        $display("%0t: res_den expected %0d, got %0d", $time,
                                 $signed(want.den), o_res_den);
                    if (o_is_equal !== want.eq)
                        $display("%0t: is_equal expected %0d, got %0d", $time,
                                 want.eq, o_is_equal);
                end
            end
        end
    end

    initial begin
        t_request         req;
        t_fraction_result want;
        int               roll;

        // request fields, typed flag, then num / den / eq where typed
        directed_rows[0]  = '{'{ramr_pkg::CMD_CMP, 16'sd5, 16'sd7, 16'sd5, 16'sd7},
                              1'b1, '{33'sd0, 32'sd0, 1'b1}};
        directed_rows[1]  = '{'{ramr_pkg::CMD_CMP, 16'sd5, 16'sd7, 16'sd7, 16'sd5},
                              1'b1, '{33'sd0, 32'sd0, 1'b0}};
        // equal value, different fields
        directed_rows[2]  = '{'{ramr_pkg::CMD_CMP, 16'sd1, 16'sd2, 16'sd2, 16'sd4},
                              1'b1, '{33'sd0, 32'sd0, 1'b0}};
        directed_rows[3]  = '{'{ramr_pkg::CMD_CMP, -16'sd32768, -16'sd32768,
                                -16'sd32768, -16'sd32768},
                              1'b1, '{33'sd0, 32'sd0, 1'b1}};
        directed_rows[4]  = '{'{ramr_pkg::CMD_CMP, 16'sd32767, -16'sd1, 16'sd32767, 16'sd1},
                              1'b1, '{33'sd0, 32'sd0, 1'b0}};
        directed_rows[5]  = '{'{CMD_UNUSED, 16'sd1, 16'sd2, 16'sd3, 16'sd4},
                              1'b1, '{33'sd0, 32'sd0, 1'b0}};
        directed_rows[6]  = '{'{CMD_UNUSED, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768},
                              1'b1, '{33'sd0, 32'sd0, 1'b0}};
        directed_rows[7]  = '{'{ramr_pkg::CMD_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
                              1'b1, '{33'sd0, 32'sd0, 1'b0}};
        directed_rows[8]  = '{'{ramr_pkg::CMD_ADD, 16'sd0, 16'sd5, 16'sd0, 16'sd7},
                              1'b1, '{33'sd0, 32'sd35, 1'b0}};
        directed_rows[9]  = '{'{ramr_pkg::CMD_MUL, 16'sd3, 16'sd0, 16'sd4, 16'sd5},
                              1'b1, '{33'sd12, 32'sd0, 1'b0}};
        directed_rows[10] = '{'{ramr_pkg::CMD_MUL, -16'sd32768, -16'sd32768,
                                -16'sd32768, -16'sd32768},
                              1'b1, '{33'sd1, 32'sd1, 1'b0}};
        directed_rows[11] = '{'{ramr_pkg::CMD_ADD, -16'sd32768, -16'sd32768,
                                -16'sd32768, -16'sd32768},
                              1'b1, '{33'sd2, 32'sd1, 1'b0}};
        directed_rows[12] = '{'{ramr_pkg::CMD_ADD, 16'sd1, -16'sd2, 16'sd1, 16'sd2},
                              1'b1, '{33'sd0, -32'sd4, 1'b0}};
        directed_rows[13] = '{'{ramr_pkg::CMD_MUL, 16'sd0, -16'sd32768, 16'sd5, 16'sd3},
                              1'b1, '{33'sd0, -32'sd98304, 1'b0}};
        directed_rows[14] = '{'{ramr_pkg::CMD_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1},
                              1'b0, '0};
        directed_rows[15] = '{'{ramr_pkg::CMD_ADD, 16'sd32767, -16'sd32768,
                                16'sd32767, -16'sd32768},
                              1'b0, '0};
        directed_rows[16] = '{'{ramr_pkg::CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3},
                              1'b0, '0};
        directed_rows[17] = '{'{ramr_pkg::CMD_MUL, -16'sd6, 16'sd4, 16'sd10, -16'sd9},
                              1'b0, '0};
        directed_rows[18] = '{'{ramr_pkg::CMD_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1},
                              1'b0, '0};
        directed_rows[19] = '{'{ramr_pkg::CMD_MUL, 16'sd32767, -16'sd32768,
                                -16'sd32768, 16'sd32767},
                              1'b0, '0};
        // repeated prime factors in both terms
        directed_rows[20] = '{'{ramr_pkg::CMD_ADD, 16'sd12, 16'sd18, 16'sd6, 16'sd9},
                              1'b0, '0};
        directed_rows[21] = '{'{ramr_pkg::CMD_ADD, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1},
                              1'b0, '0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            want = directed_rows[i].typed ? directed_rows[i].want
                                          : predict_fraction(directed_rows[i].req);
            send_request(directed_rows[i].req, want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 72;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 30;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    req.cmd = ramr_pkg::CMD_ADD;
                else if (roll < 80)
                    req.cmd = ramr_pkg::CMD_MUL;
                else if (roll < 95)
                    req.cmd = ramr_pkg::CMD_CMP;
                else
                    req.cmd = CMD_UNUSED;
                req.a_num = pick_operand();
                req.a_den = pick_operand();
                // compare needs matching fields often enough to hit equality
                if (req.cmd == ramr_pkg::CMD_CMP && $urandom_range(0, 1) == 1) begin
                    req.b_num = req.a_num;
                    req.b_den = ($urandom_range(0, 3) == 0) ? pick_operand() : req.a_den;
                end else begin
                    req.b_num = pick_operand();
                    req.b_den = pick_operand();
                end
                send_request(req, predict_fraction(req));
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
